>>> rtl/atp_pkg.sv
// ----------------------------------------------------------------------------
// atp_pkg: shared types and constants for the ANSI text terminal parser
// Holds the result word layout, result kinds, screen limits and the palette.
// ----------------------------------------------------------------------------
package atp_pkg;

    // Screen and parser limits
    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_PARAMS = 4;
    localparam int PIDX_W     = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    // Default colors after reset or SGR 0
    localparam logic [23:0] RESET_FORE = 24'hbac2de;
    localparam logic [23:0] RESET_BACK = 24'h181825;

    // Result kinds
    localparam logic [1:0] KIND_CELL   = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_MOVE   = 2'd2;

    // Special bytes
    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_CSI  = 8'h5b;
    localparam logic [7:0] CH_SGR  = 8'h6d;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // One result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  cell_row;
        logic [6:0]  cell_col;
        logic [7:0]  glyph;
        logic [23:0] fore_color;
        logic [23:0] back_color;
        logic [6:0]  cursor_col_out;
        logic [5:0]  cursor_row_out;
        logic        last;
    } res_t;

    // Character action handed from the parser to the cursor unit
    typedef struct packed {
        logic        char_valid;
        logic [7:0]  char_code;
        logic [23:0] fore;
        logic [23:0] back;
    } act_t;

    // Eight-entry RGB palette
    function automatic logic [23:0] palette(input logic [2:0] idx);
        logic [23:0] rgb;
        case (idx)
            3'd0:    rgb = 24'h181825;
            3'd1:    rgb = 24'hf38ba8;
            3'd2:    rgb = 24'ha6e3a1;
            3'd3:    rgb = 24'hf9e2af;
            3'd4:    rgb = 24'h89b4fa;
            3'd5:    rgb = 24'hcba6f7;
            3'd6:    rgb = 24'h6c7086;
            default: rgb = 24'hbac2de;
        endcase
        return rgb;
    endfunction

endpackage

>>> rtl/atp_parser.sv
// ----------------------------------------------------------------------------
// atp_parser: escape and CSI parser with SGR color state
// Tracks the parse mode and parameters, applies SGR codes to the current
// colors and flags the bytes that the cursor unit must handle as characters.
// ----------------------------------------------------------------------------
module atp_parser (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   text_byte,
    output atp_pkg::act_t act
);
    import atp_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_CSI    = 2'd2;

    logic [1:0]        mode_reg, mode_next;
    logic [7:0]        params_reg [MAX_PARAMS];
    logic [7:0]        params_next [MAX_PARAMS];
    logic [PIDX_W-1:0] pidx_reg, pidx_next;
    logic [23:0]       fore_reg, fore_next;
    logic [23:0]       back_reg, back_next;

    logic              is_digit;
    logic [11:0]       digit_acc;
    logic [23:0]       sgr_fore, sgr_back;

    assign is_digit  = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    // Current parameter times ten plus the new digit
    assign digit_acc = {1'b0, params_reg[pidx_reg], 3'b000}
                     + {3'b000, params_reg[pidx_reg], 1'b0}
                     + {8'h00, text_byte[3:0]};

    // Apply the collected SGR codes in order
    always_comb
    begin
        logic [7:0] code;
        sgr_fore = fore_reg;
        sgr_back = back_reg;
        for (int i = 0; i < MAX_PARAMS; i++)
        begin
            code = params_reg[i];
            if (PIDX_W'(i) <= pidx_reg)
            begin
                if (code == 8'd0)
                begin
                    sgr_fore = RESET_FORE;
                    sgr_back = RESET_BACK;
                end
                else if (code >= 8'd30 && code <= 8'd37)
                begin
                    sgr_fore = palette(3'(code - 8'd30));
                end
                else if (code >= 8'd40 && code <= 8'd47)
                begin
                    sgr_back = palette(3'(code - 8'd40));
                end
            end
        end
    end

    // Next parse state
    always_comb
    begin
        mode_next = mode_reg;
        pidx_next = pidx_reg;
        fore_next = fore_reg;
        back_next = back_reg;
        for (int i = 0; i < MAX_PARAMS; i++)
        begin
            params_next[i] = params_reg[i];
        end
        act.char_valid = 1'b0;
        act.char_code  = text_byte;
        act.fore       = fore_reg;
        act.back       = back_reg;

        if (text_byte != 8'h00)
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    if (text_byte == CH_CSI)
                    begin
                        mode_next      = MODE_CSI;
                        pidx_next      = '0;
                        params_next[0] = 8'd0;
                    end
                    else
                    begin
                        mode_next      = MODE_NORMAL;
                        act.char_valid = 1'b1;
                    end
                end
                MODE_CSI:
                begin
                    if (is_digit)
                    begin
                        params_next[pidx_reg] = (digit_acc > 12'd255) ? 8'd255
                                                                       : digit_acc[7:0];
                    end
                    else if (text_byte == CH_SEMI)
                    begin
                        if (32'(pidx_reg) + 1 < MAX_PARAMS)
                        begin
                            pidx_next              = pidx_reg + 1'b1;
                            params_next[pidx_next] = 8'd0;
                        end
                    end
                    else
                    begin
                        // Final byte: only 'm' changes the colors
                        if (text_byte == CH_SGR)
                        begin
                            fore_next = sgr_fore;
                            back_next = sgr_back;
                        end
                        mode_next      = MODE_NORMAL;
                        pidx_next      = '0;
                        params_next[0] = 8'd0;
                    end
                end
                default:
                begin
                    if (text_byte == CH_ESC)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        mode_next      = MODE_NORMAL;
                        act.char_valid = 1'b1;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            pidx_reg <= '0;
            fore_reg <= RESET_FORE;
            back_reg <= RESET_BACK;
            for (int i = 0; i < MAX_PARAMS; i++)
            begin
                params_reg[i] <= 8'd0;
            end
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            pidx_reg <= pidx_next;
            fore_reg <= fore_next;
            back_reg <= back_next;
            for (int i = 0; i < MAX_PARAMS; i++)
            begin
                params_reg[i] <= params_next[i];
            end
        end
    end

endmodule

>>> rtl/atp_cursor.sv
// ----------------------------------------------------------------------------
// atp_cursor: cursor tracking and result generation
// Moves the cursor for characters, newline and backspace, wraps at the
// column count and forms the cell write, scroll and move results.
// ----------------------------------------------------------------------------
module atp_cursor (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  atp_pkg::act_t act,
    input  logic [7:0]    columns,
    input  logic [6:0]    row_count,
    output logic [1:0]    push_count,
    output atp_pkg::res_t res0,
    output atp_pkg::res_t res1
);
    import atp_pkg::*;

    logic [6:0] col_reg, col_next;
    logic [5:0] row_reg, row_next;

    logic [7:0] cols;
    logic [6:0] rows;

    // Effective screen size
    assign cols = (columns == 8'd0) ? 8'd1
                : (columns > 8'(MAX_COLS)) ? 8'(MAX_COLS) : columns;
    assign rows = (row_count == 7'd0) ? 7'd1
                : (row_count > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : row_count;

    // Cursor step and results for one character
    always_comb
    begin
        logic [7:0] c_col;
        logic [6:0] c_row;
        logic       wrote;
        logic       scroll;
        res_t       write_word;
        res_t       other;

        c_col = {1'b0, col_reg};
        c_row = {1'b0, row_reg};
        if (c_col >= cols)
        begin
            c_col = cols - 8'd1;
        end
        if (c_row >= rows)
        begin
            c_row = rows - 7'd1;
        end

        write_word            = '0;
        write_word.kind       = KIND_CELL;
        write_word.fore_color = act.fore;
        write_word.back_color = act.back;
        wrote                 = 1'b0;

        if (act.char_code == CH_LF)
        begin
            c_col = 8'd0;
            c_row = c_row + 7'd1;
        end
        else if (act.char_code == CH_BS)
        begin
            if (c_col != 8'd0)
            begin
                c_col = c_col - 8'd1;
            end
            else if (c_row != 7'd0)
            begin
                c_row = c_row - 7'd1;
                c_col = cols - 8'd1;
            end
            write_word.cell_row = c_row[5:0];
            write_word.cell_col = c_col[6:0];
            write_word.glyph    = 8'd0;
            wrote               = 1'b1;
        end
        else
        begin
            write_word.cell_row = c_row[5:0];
            write_word.cell_col = c_col[6:0];
            write_word.glyph    = act.char_code;
            wrote               = 1'b1;
            c_col               = c_col + 8'd1;
            if (c_col >= cols)
            begin
                c_col = 8'd0;
                c_row = c_row + 7'd1;
            end
        end

        // Passing the last row scrolls and pulls the cursor back
        scroll = (c_row >= rows);
        if (scroll)
        begin
            c_row = c_row - 7'd1;
        end

        other = '0;
        if (scroll)
        begin
            other.kind       = KIND_SCROLL;
            other.fore_color = act.fore;
            other.back_color = act.back;
        end
        else
        begin
            other.kind = KIND_MOVE;
        end

        write_word.cursor_col_out = c_col[6:0];
        write_word.cursor_row_out = c_row[5:0];
        other.cursor_col_out      = c_col[6:0];
        other.cursor_row_out      = c_row[5:0];
        other.last                = 1'b1;
        write_word.last           = !scroll;

        col_next = c_col[6:0];
        row_next = c_row[5:0];

        if (!act.char_valid)
        begin
            push_count = 2'd0;
            res0       = other;
            res1       = other;
        end
        else if (wrote)
        begin
            push_count = scroll ? 2'd2 : 2'd1;
            res0       = write_word;
            res1       = other;
        end
        else
        begin
            push_count = 2'd1;
            res0       = other;
            res1       = other;
        end
    end

    // Cursor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 7'd0;
            row_reg <= 6'd0;
        end
        else if (fire && act.char_valid)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> rtl/atp_result_fifo.sv
// ----------------------------------------------------------------------------
// atp_result_fifo: four-word result queue
// Takes up to two result words per cycle and hands out one per cycle when popped.
// ----------------------------------------------------------------------------
module atp_result_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_count,
    input  atp_pkg::res_t push0,
    input  atp_pkg::res_t push1,
    input  logic          pop,
    output logic          has_room,
    output logic          not_empty,
    output atp_pkg::res_t head
);
    import atp_pkg::*;

    res_t       entries [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic [1:0] wr_ptr1;

    assign wr_ptr1   = wr_ptr_reg + 2'd1;
    assign has_room  = (count_reg <= 3'd2);
    assign not_empty = (count_reg != 3'd0);
    assign head      = entries[rd_ptr_reg];

    // Word storage
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entries[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entries[wr_ptr1] <= push1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_count;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {1'b0, push_count} - {2'b00, pop};
        end
    end

endmodule

>>> rtl/ansi_text_terminal_parser_core.sv
// ----------------------------------------------------------------------------
// ansi_text_terminal_parser_core: character stream front end of a text terminal
// Parses escape and CSI sequences, applies SGR colors and turns text bytes
// into cell write, scroll and cursor move result words.
//
//   Channel  Direction  Handshake             Payload
//   s        in         s_tvalid / s_tready   s_tdata: text byte
//   m        out        m_tvalid / m_tready   m_tdata, m_tuser (kind), m_tlast
//   cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A byte is held in an input register and handled once the result queue
// has room for two words; the output side drains one word a cycle while
// m_tready is high, and a byte that writes a cell and scrolls yields two words.
// Reset restores the default colors, home cursor, 80 columns and 25 rows.
// The input stalls while three or more words wait in the four-word queue.
// ----------------------------------------------------------------------------
module ansi_text_terminal_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] cell_row, [12:6] cell_col, [20:13] glyph, [44:21] fore_color,
    // [68:45] back_color, [75:69] cursor_col_out, [81:76] cursor_row_out,
    // [87:82] zero
    output logic [87:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import atp_pkg::*;

    localparam logic [3:0] REG_COLUMNS   = 4'd0;
    localparam logic [3:0] REG_ROW_COUNT = 4'd1;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] columns_reg;
    logic [6:0] row_count_reg;

    logic       fire;
    logic       has_room;
    logic       not_empty;
    logic [1:0] push_count;
    logic [1:0] push_gated;
    act_t       act;
    res_t       res0, res1, head;

    assign fire       = in_valid_reg && has_room;
    assign s_tready   = !in_valid_reg || fire;
    assign push_gated = fire ? push_count : 2'd0;
    assign cfg_ready  = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= 8'd80;
            row_count_reg <= 7'd25;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COLUMNS:   columns_reg   <= cfg_data;
                REG_ROW_COUNT: row_count_reg <= cfg_data[6:0];
                default:       ;
            endcase
        end
    end

    atp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .text_byte (in_byte_reg),
        .act       (act)
    );

    atp_cursor u_cursor (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .act        (act),
        .columns    (columns_reg),
        .row_count  (row_count_reg),
        .push_count (push_count),
        .res0       (res0),
        .res1       (res1)
    );

    atp_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_gated),
        .push0      (res0),
        .push1      (res1),
        .pop        (m_tvalid && m_tready),
        .has_room   (has_room),
        .not_empty  (not_empty),
        .head       (head)
    );

    // Output word packing
    assign m_tvalid = not_empty;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {6'd0, head.cursor_row_out, head.cursor_col_out, head.back_color,
                       head.fore_color, head.glyph, head.cell_col, head.cell_row};

endmodule

>>> dv/ansi_text_terminal_parser_core_test.sv
// ----------------------------------------------------------------------------
// ansi_text_terminal_parser_core_test: self-checking bench for the terminal parser
// Feeds text bytes, escape and SGR sequences through the stream input, keeps
// its own model of parser, colors and cursor, and compares every result word
// with the oldest predicted word. The screen size is changed between phases,
// both sides idle at random, and one phase holds the output off for a long
// stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module ansi_text_terminal_parser_core_test;

    import atp_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE       = 16;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int RUN_LIMIT    = 5_000_000;
    localparam int SHOW_LIMIT   = 10;
    localparam int LONG_HOLD    = 400;

    // Register indexes of the configuration channel
    localparam logic [3:0] REG_COLUMNS   = 4'd0;
    localparam logic [3:0] REG_ROW_COUNT = 4'd1;
    localparam logic [3:0] REG_SPARE     = 4'd15;

    // Bytes and SGR codes the bench needs beyond the package
    localparam logic [7:0] CH_NUL         = 8'h00;
    localparam int         SGR_RESET      = 0;
    localparam int         SGR_FORE_FIRST = 30;
    localparam int         SGR_FORE_LAST  = 37;
    localparam int         SGR_BACK_FIRST = 40;
    localparam int         SGR_BACK_LAST  = 47;
    localparam int         PARAM_CEILING  = 255;

    typedef enum logic [1:0] {PARSE_TEXT, PARSE_ESCAPE, PARSE_CSI} parse_mode_e;

    // Tracks parser, colors and cursor, and holds the words still due
    class terminal_scoreboard;
        res_t        due_words[$];
        int          failures;
        int unsigned columns_reg;
        int unsigned rows_reg;
        parse_mode_e mode;
        int unsigned params[MAX_PARAMS];
        int unsigned pidx;
        logic [23:0] fore;
        logic [23:0] back;
        int unsigned cur_col;
        int unsigned cur_row;
        logic [23:0] palette_rgb[8];

        function new();
            palette_rgb = '{24'h181825, 24'hf38ba8, 24'ha6e3a1, 24'hf9e2af,
                            24'h89b4fa, 24'hcba6f7, 24'h6c7086, 24'hbac2de};
            failures    = 0;
            columns_reg = 80;
            rows_reg    = 25;
            mode        = PARSE_TEXT;
            foreach (params[i])
                params[i] = 0;
            pidx        = 0;
            fore        = RESET_FORE;
            back        = RESET_BACK;
            cur_col     = 0;
            cur_row     = 0;
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= SHOW_LIMIT)
                $display("ERROR @%0t: %s", $realtime, what);
        endfunction

        function string show(res_t w);
            return $sformatf("kind=%0d cell=(%0d,%0d) glyph=%02h fg=%06h bg=%06h cur=(%0d,%0d) last=%0b",
                             w.kind, w.cell_row, w.cell_col, w.glyph, w.fore_color,
                             w.back_color, w.cursor_row_out, w.cursor_col_out, w.last);
        endfunction

        function void set_register(logic [3:0] idx, logic [7:0] val);
            if (idx == REG_COLUMNS)
                columns_reg = val;
            else if (idx == REG_ROW_COUNT)
                rows_reg = val[6:0];
        endfunction

        function res_t make_word(logic [1:0] k, int unsigned r, int unsigned col_i,
                                 logic [7:0] g, logic [23:0] f, logic [23:0] b);
            res_t w;
            w                = '0;
            w.kind           = k;
            w.cell_row       = 6'(r);
            w.cell_col       = 7'(col_i);
            w.glyph          = g;
            w.fore_color     = f;
            w.back_color     = b;
            return w;
        endfunction

        function void apply_sgr(int unsigned code);
            if (code == SGR_RESET)
            begin
                fore = RESET_FORE;
                back = RESET_BACK;
            end
            else if (code >= SGR_FORE_FIRST && code <= SGR_FORE_LAST)
                fore = palette_rgb[code - SGR_FORE_FIRST];
            else if (code >= SGR_BACK_FIRST && code <= SGR_BACK_LAST)
                back = palette_rgb[code - SGR_BACK_FIRST];
        endfunction

        // A character outside a sequence: cell write, cursor move and maybe a scroll
        function void place_char(logic [7:0] c);
            int unsigned cols;
            int unsigned rows;
            res_t        words[$];
            cols = (columns_reg == 0) ? 1 : ((columns_reg > MAX_COLS) ? MAX_COLS : columns_reg);
            rows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
            if (cur_col >= cols)
                cur_col = cols - 1;
            if (cur_row >= rows)
                cur_row = rows - 1;

            if (c == CH_LF)
            begin
                cur_col = 0;
                cur_row++;
            end
            else if (c == CH_BS)
            begin
                if (cur_col > 0)
                    cur_col--;
                else if (cur_row > 0)
                begin
                    cur_row--;
                    cur_col = cols - 1;
                end
                words.push_back(make_word(KIND_CELL, cur_row, cur_col, 8'h00, fore, back));
            end
            else
            begin
                words.push_back(make_word(KIND_CELL, cur_row, cur_col, c, fore, back));
                cur_col++;
                if (cur_col >= cols)
                begin
                    cur_col = 0;
                    cur_row++;
                end
            end

            if (cur_row >= rows)
            begin
                if (cur_row > 0)
                    cur_row--;
                words.push_back(make_word(KIND_SCROLL, 0, 0, 8'h00, fore, back));
            end
            else if (words.size() == 0)
                words.push_back(make_word(KIND_MOVE, 0, 0, 8'h00, 24'h0, 24'h0));

            foreach (words[i])
            begin
                words[i].cursor_col_out = 7'(cur_col);
                words[i].cursor_row_out = 6'(cur_row);
                words[i].last           = (i == words.size() - 1);
                due_words.push_back(words[i]);
            end
        endfunction

        // One accepted input byte
        function void accept_byte(logic [7:0] c);
            int unsigned v;
            int unsigned count;
            if (c == CH_NUL)
                return;
            case (mode)
                PARSE_ESCAPE:
                begin
                    if (c == CH_CSI)
                    begin
                        mode      = PARSE_CSI;
                        pidx      = 0;
                        params[0] = 0;
                    end
                    else
                    begin
                        mode = PARSE_TEXT;
                        place_char(c);
                    end
                end
                PARSE_CSI:
                begin
                    if (c >= CH_ZERO && c <= CH_NINE)
                    begin
                        v            = params[pidx] * 10 + (c - CH_ZERO);
                        params[pidx] = (v > PARAM_CEILING) ? PARAM_CEILING : v;
                    end
                    else if (c == CH_SEMI)
                    begin
                        if (pidx + 1 < MAX_PARAMS)
                        begin
                            pidx++;
                            params[pidx] = 0;
                        end
                    end
                    else
                    begin
                        count = (pidx == 0 && params[0] == 0) ? 0 : pidx + 1;
                        if (c == CH_SGR)
                        begin
                            if (count == 0)
                                apply_sgr(SGR_RESET);
                            else
                                for (int i = 0; i < count; i++)
                                    apply_sgr(params[i]);
                        end
                        mode      = PARSE_TEXT;
                        pidx      = 0;
                        params[0] = 0;
                    end
                end
                default:
                begin
                    if (c == CH_ESC)
                        mode = PARSE_ESCAPE;
                    else
                        place_char(c);
                end
            endcase
        endfunction

        // One accepted result word against the oldest prediction
        function void check_word(res_t got);
            res_t want;
            if (due_words.size() == 0)
            begin
                flag($sformatf("unexpected word: %s", show(got)));
                return;
            end
            want = due_words.pop_front();
            if (got.kind !== want.kind || got.cell_row !== want.cell_row ||
                got.cell_col !== want.cell_col || got.glyph !== want.glyph ||
                got.fore_color !== want.fore_color || got.back_color !== want.back_color ||
                got.cursor_col_out !== want.cursor_col_out ||
                got.cursor_row_out !== want.cursor_row_out || got.last !== want.last)
                flag($sformatf("word mismatch\n  expected %s\n  actual   %s",
                               show(want), show(got)));
        endfunction

        function void close_out();
            if (due_words.size() != 0)
            begin
                failures += due_words.size();
                $display("ERROR: %0d predicted words never arrived", due_words.size());
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [7:0]  cfg_data;

    terminal_scoreboard sb;
    int                 sent_items;
    int                 rx_hold;
    bit                 no_idle;

    ansi_text_terminal_parser_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
        clk = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // Offer one byte after a random gap; tvalid stays high on return
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.accept_byte(b);
        if (b != CH_NUL)
            sent_items++;
    endtask

    // SGR or other CSI sequence with random parameters and final byte
    task automatic send_sgr();
        int         nparm;
        int         pick;
        int         code;
        string      digits;
        logic [7:0] fin;
        send_byte(CH_ESC);
        send_byte(CH_CSI);
        nparm = $urandom_range(0, 6);
        for (int i = 0; i < nparm; i++)
        begin
            if (i > 0)
                send_byte(CH_SEMI);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       code = SGR_RESET;
                1, 2, 3: code = SGR_FORE_FIRST + $urandom_range(0, 7);
                4, 5, 6: code = SGR_BACK_FIRST + $urandom_range(0, 7);
                7:       code = $urandom_range(0, 255);
                8:       code = $urandom_range(256, 99999);
                default: code = -1;
            endcase
            if (code >= 0)
            begin
                digits = $sformatf("%0d", code);
                if ($urandom_range(0, 7) == 0)
                    digits = {"0", digits};
                for (int k = 0; k < digits.len(); k++)
                    send_byte(digits[k]);
            end
            if ($urandom_range(0, 19) == 0)
                send_byte(CH_NUL);
        end
        if ($urandom_range(0, 7) != 0)
            fin = CH_SGR;
        else
        begin
            do
                fin = 8'($urandom_range(1, 255));
            while ((fin >= CH_ZERO && fin <= CH_NINE) || fin == CH_SEMI);
        end
        send_byte(fin);
    endtask

    // Mostly text, newlines, backspaces and color sequences, some noise
    task automatic send_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_byte(8'($urandom_range(32, 126)));
        else if (pick < 52)
            send_byte(CH_LF);
        else if (pick < 60)
            send_byte(CH_BS);
        else if (pick < 82)
            send_sgr();
        else if (pick < 88)
        begin
            send_byte(CH_ESC);
            send_byte(8'($urandom_range(1, 255)));
        end
        else if (pick < 92)
            send_byte(CH_NUL);
        else
            send_byte(8'($urandom_range(1, 255)));
    endtask

    // Wait until every predicted word is in and the block has gone quiet
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (sb.due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, val);
    endtask

    task automatic program_screen(input logic [7:0] cols, input logic [7:0] rows,
                                  input bit touch_spare);
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_ROW_COUNT, rows);
        if (touch_spare)
            write_reg(REG_SPARE, 8'haa);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] cols, input logic [7:0] rows,
                             input bit touch_spare, input int count);
        int target;
        quiesce();
        program_screen(cols, rows, touch_spare);
        target = sent_items + count;
        while (sent_items < target)
            send_token();
    endtask

    // Output side: random stalls, one long hold-off on request
    initial
    begin
        int   gap;
        res_t got;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap     = (rx_hold > 0) ? rx_hold : draw_gap();
            rx_hold = 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.kind           = m_tuser;
            got.cell_row       = m_tdata[5:0];
            got.cell_col       = m_tdata[12:6];
            got.glyph          = m_tdata[20:13];
            got.fore_color     = m_tdata[44:21];
            got.back_color     = m_tdata[68:45];
            got.cursor_col_out = m_tdata[75:69];
            got.cursor_row_out = m_tdata[81:76];
            got.last           = m_tlast;
            sb.check_word(got);
        end
    end

    // Main sequence
    initial
    begin
        logic [7:0] opening[$];
        logic [7:0] wrap_run[$];
        int         waited;
        sb         = new();
        sent_items = 0;
        rx_hold    = 0;
        no_idle    = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        cfg_valid  = 1'b0;
        cfg_index  = 4'h0;
        cfg_data   = 8'h00;

        // Backspace at home, extreme glyphs, ignored zero, two-code SGR, newline,
        // backspace across a row, dropped escapes and an empty SGR list.
        opening  = '{CH_BS, "A", CH_NUL, 8'hff, CH_ESC, CH_CSI, "3", "1", CH_SEMI,
                     "4", "4", CH_SGR, CH_LF, CH_BS, CH_ESC, "Q", CH_ESC, CH_ESC,
                     CH_ESC, CH_CSI, CH_SGR};
        // On a 4x2 screen: wrap, newline scroll, cell write followed by scroll
        wrap_run = '{"a", "b", "c", "d", CH_LF, "e", "f", "g", "h"};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_byte(opening[i]);
        quiesce();
        program_screen(8'd4, 8'd2, 1'b0);
        foreach (wrap_run[i])
            send_byte(wrap_run[i]);

        run_phase(8'd1, 8'd1, 1'b0, 100);
        run_phase(8'd128, 8'd64, 1'b0, 110);
        // Zero sizes act as one; the cursor is pulled in from the big screen
        run_phase(8'd0, 8'h80, 1'b0, 80);
        run_phase(8'hff, 8'hff, 1'b0, 90);

        // Long output hold-off while input keeps coming
        quiesce();
        rx_hold = LONG_HOLD;
        run_phase(8'd7, 8'd3, 1'b1, 120);

        no_idle = 1'b1;
        run_phase(8'($urandom_range(2, 20)), 8'($urandom_range(2, 8)), 1'b0, 100);
        no_idle = 1'b0;

        run_phase(8'd80, 8'd25, 1'b0, 100);
        run_phase(8'd2, 8'd4, 1'b0, 100);

        // Drain and close out
        s_tvalid <= 1'b0;
        waited = 0;
        while (sb.due_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        sb.close_out();

        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
